// File: sv/q7_8_saturating_alu_unit_macros.svh
// Assertion macros used by the Q7.8 ALU top level.
`ifndef Q7_8_SATURATING_ALU_UNIT_MACROS_SVH
`define Q7_8_SATURATING_ALU_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk and switched off while rst_n is low.
`define Q78ALU_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("q78alu: same-cycle check failed");

// Next-cycle implication, sampled on clk and switched off while rst_n is low.
`define Q78ALU_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("q78alu: next-cycle check failed");

`endif

// File: sv/q78alu_pkg.sv
// Types and constants of the Q7.8 saturating ALU.
package q78alu_pkg;

    localparam int DATA_W = 16;
    localparam int FRAC_BITS = 8;
    localparam int DVD_W = DATA_W + FRAC_BITS;
    localparam int NUM_CELLS = DVD_W;

    localparam logic signed [DATA_W-1:0] Q_MAX = 16'sh7FFF;
    localparam logic signed [DATA_W-1:0] Q_MIN = 16'sh8000;

    typedef enum logic [1:0] {
        OP_ADD = 2'd0,
        OP_SUB = 2'd1,
        OP_MUL = 2'd2,
        OP_DIV = 2'd3
    } q78alu_op_t;

    // Payload carried from stage to stage along the divider chain.
    typedef struct packed {
        logic              is_div;
        logic              neg;
        logic              dz;
        logic [DATA_W-1:0] fixed;
        logic [DATA_W-1:0] dvsr;
        logic [DATA_W-1:0] rem;
        logic [DVD_W-1:0]  dq;
    } q78alu_stage_t;

endpackage

// File: sv/q78alu_front.sv
// Entry stage: add, subtract and multiply with saturation, and division set-up.
module q78alu_front
    import q78alu_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [1:0]               op,
    input  logic signed [DATA_W-1:0] a,
    input  logic signed [DATA_W-1:0] b,
    output logic                     out_valid,
    input  logic                     out_stall,
    output q78alu_stage_t            out_data
);

    logic          valid_reg;
    logic          valid_next;
    q78alu_stage_t data_reg;
    q78alu_stage_t data_next;

    logic signed [DATA_W:0]     sum;
    logic signed [2*DATA_W-1:0] prod;
    logic signed [DVD_W-1:0]    prod_sh;
    logic [DATA_W-1:0]          sum_sat;
    logic [DATA_W-1:0]          mul_sat;
    logic [DATA_W-1:0]          amag;
    logic [DATA_W-1:0]          bmag;
    q78alu_op_t                 op_code;

    assign op_code = q78alu_op_t'(op);

    always_comb
    begin
        if (op_code == OP_SUB)
        begin
            sum = $signed({a[DATA_W-1], a}) - $signed({b[DATA_W-1], b});
        end
        else
        begin
            sum = $signed({a[DATA_W-1], a}) + $signed({b[DATA_W-1], b});
        end
        if (sum > $signed({1'b0, Q_MAX}))
        begin
            sum_sat = Q_MAX;
        end
        else if (sum < $signed({1'b1, Q_MIN}))
        begin
            sum_sat = Q_MIN;
        end
        else
        begin
            sum_sat = sum[DATA_W-1:0];
        end
    end

    // The arithmetic shift by the fraction width floors negative products.
    assign prod    = a * b;
    assign prod_sh = prod[2*DATA_W-1:FRAC_BITS];

    always_comb
    begin
        if (prod_sh > $signed({{FRAC_BITS{1'b0}}, Q_MAX}))
        begin
            mul_sat = Q_MAX;
        end
        else if (prod_sh < $signed({{FRAC_BITS{1'b1}}, Q_MIN}))
        begin
            mul_sat = Q_MIN;
        end
        else
        begin
            mul_sat = prod_sh[DATA_W-1:0];
        end
    end

    // Magnitudes as unsigned values; the most negative operand gives 2^15.
    assign amag = a[DATA_W-1] ? (~a + 1'b1) : a;
    assign bmag = b[DATA_W-1] ? (~b + 1'b1) : b;

    always_comb
    begin
        data_next.is_div = (op_code == OP_DIV);
        data_next.neg    = a[DATA_W-1] ^ b[DATA_W-1];
        data_next.dz     = (b == '0);
        data_next.dvsr   = bmag;
        data_next.rem    = '0;
        data_next.dq     = {amag, {FRAC_BITS{1'b0}}};
        unique case (op_code)
            OP_ADD, OP_SUB: data_next.fixed = sum_sat;
            OP_MUL:         data_next.fixed = mul_sat;
            OP_DIV:         data_next.fixed = a[DATA_W-1] ? Q_MIN : Q_MAX;
            default:        data_next.fixed = sum_sat;
        endcase
    end

    assign in_stall   = valid_reg && out_stall;
    assign valid_next = in_stall ? valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: sv/q78alu_cell.sv
// One restoring division step: a quotient bit per cell, payload handed onwards.
module q78alu_cell
    import q78alu_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  q78alu_stage_t in_data,
    output logic          out_valid,
    input  logic          out_stall,
    output q78alu_stage_t out_data
);

    logic          valid_reg;
    logic          valid_next;
    q78alu_stage_t data_reg;
    q78alu_stage_t data_next;

    logic [DATA_W:0] trial;
    logic [DATA_W:0] diff;
    logic            ge;

    assign trial = {in_data.rem, in_data.dq[DVD_W-1]};
    assign diff  = trial - {1'b0, in_data.dvsr};
    assign ge    = (trial >= {1'b0, in_data.dvsr});

    always_comb
    begin
        data_next     = in_data;
        data_next.rem = ge ? diff[DATA_W-1:0] : trial[DATA_W-1:0];
        data_next.dq  = {in_data.dq[DVD_W-2:0], ge};
    end

    assign in_stall   = valid_reg && out_stall;
    assign valid_next = in_stall ? valid_reg : in_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: sv/q7_8_saturating_alu_unit.sv
// Top level of the Q7.8 saturating ALU: entry stage, divider cell chain, result register.
//
//   channel | direction | handshake            | payload
//   req     | in        | req_valid, req_stall | op, a, b
//   rsp     | out       | rsp_valid, rsp_stall | result
//
// A new beat may be taken on every cycle; each item passes through 26 registered
// stages (the entry stage, 24 division cells and the result register) whatever the
// operation. The 24 one-bit restoring steps of the divider set that depth. Reset
// clears only the valid flags of the stages. A stall on rsp holds the result
// register; a stage upstream keeps taking beats while any stage ahead of it is
// empty, and req_stall rises only once the chain in front of the entry stage
// is full.
module q7_8_saturating_alu_unit
    import q78alu_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     req_valid,
    output logic                     req_stall,
    input  logic [1:0]               op,
    input  logic signed [DATA_W-1:0] a,
    input  logic signed [DATA_W-1:0] b,
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output logic signed [DATA_W-1:0] result
);

`include "q7_8_saturating_alu_unit_macros.svh"

    // Stage 0 is the entry stage; stages 1 to NUM_CELLS are the division cells.
    logic          stg_valid [0:NUM_CELLS];
    logic          stg_stall [0:NUM_CELLS];
    q78alu_stage_t stg_data  [0:NUM_CELLS];

    logic                     out_stall;
    logic                     rsp_valid_reg;
    logic                     rsp_valid_next;
    logic signed [DATA_W-1:0] result_reg;
    logic signed [DATA_W-1:0] result_next;
    q78alu_stage_t            last;

    q78alu_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req_valid),
        .in_stall  (req_stall),
        .op        (op),
        .a         (a),
        .b         (b),
        .out_valid (stg_valid[0]),
        .out_stall (stg_stall[0]),
        .out_data  (stg_data[0])
    );

    // Each cell reports its own stall back to the stage before it.
    for (genvar gi = 1; gi <= NUM_CELLS; gi++)
    begin : g_cell
        q78alu_cell u_cell
        (
            .clk       (clk),
            .rst_n     (rst_n),
            .in_valid  (stg_valid[gi-1]),
            .in_stall  (stg_stall[gi-1]),
            .in_data   (stg_data[gi-1]),
            .out_valid (stg_valid[gi]),
            .out_stall (stg_stall[gi]),
            .out_data  (stg_data[gi])
        );
    end

    // The result register only blocks the chain while it holds an unread beat.
    assign out_stall            = rsp_valid_reg && rsp_stall;
    assign stg_stall[NUM_CELLS] = out_stall;
    assign last                 = stg_data[NUM_CELLS];

    // Sign correction and clamping of the quotient. The quotient magnitude may
    // reach 2^23, so anything beyond the 16-bit range saturates; a negative
    // quotient of exactly 2^15 is still representable.
    always_comb
    begin
        if (last.is_div && !last.dz)
        begin
            if (last.neg)
            begin
                if (last.dq > DVD_W'(32768))
                begin
                    result_next = Q_MIN;
                end
                else
                begin
                    result_next = ~last.dq[DATA_W-1:0] + 1'b1;
                end
            end
            else
            begin
                if (last.dq > DVD_W'(32767))
                begin
                    result_next = Q_MAX;
                end
                else
                begin
                    result_next = last.dq[DATA_W-1:0];
                end
            end
        end
        else
        begin
            // Add, subtract, multiply and division by zero were settled at entry.
            result_next = last.fixed;
        end
    end

    assign rsp_valid_next = out_stall ? rsp_valid_reg : stg_valid[NUM_CELLS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!out_stall && stg_valid[NUM_CELLS])
        begin
            result_reg <= result_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign result    = result_reg;

    // The input can only be held off while the entry stage holds a beat.
    `Q78ALU_ASSERT_IMP(a_req_stall_needs_entry, req_stall, stg_valid[0])
    // A fresh result must have come out of the last division cell.
    `Q78ALU_ASSERT_IMP(a_rsp_from_chain, $rose(rsp_valid), $past(stg_valid[NUM_CELLS]))
    // A divide by zero taken at the input is marked as such in the entry stage.
    `Q78ALU_ASSERT_NXT(a_div_zero_marked,
        req_valid && !req_stall && (op == OP_DIV) && (b == '0),
        stg_valid[0] && stg_data[0].is_div && stg_data[0].dz)

endmodule
